FILE: hw/rtl/lpf_pkg.sv
package lpf_pkg;

	localparam int MAX_LEN  = 1024;
	localparam int BYTE_AW  = $clog2(MAX_LEN);
	localparam int CNT_W    = $clog2(MAX_LEN + 1);
	localparam int IL_DEPTH = 2 * MAX_LEN + 1;
	localparam int IL_W     = $clog2(IL_DEPTH);
	localparam int SYM_W    = 8;
	localparam int START_W  = 10;
	localparam int LEN_W    = 11;

	// one closed string handed from the loader to the search engine
	typedef struct packed {
		logic [CNT_W-1:0] n;
		logic             ovf;
	} job_t;

	// byte store write port driven by the loader
	typedef struct packed {
		logic               we;
		logic [BYTE_AW-1:0] addr;
		logic [SYM_W-1:0]   data;
	} bwr_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_POS,
		S_MIR,
		S_CHK,
		S_CMP,
		S_UPD,
		S_FIN
	} srch_state_t;

endpackage

FILE: hw/rtl/lpf_ram.sv
module lpf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/lpf_front.sv
module lpf_front import lpf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [SYM_W-1:0] symbol,
	input  logic             last_symbol,
	input  logic             hold,
	output bwr_t             bwr,
	output logic             push,
	output job_t             job
);

	logic [CNT_W-1:0] count_q;
	logic             ovf_q;
	logic             take;
	logic             room;

	assign in_stall = hold;
	assign take     = in_valid && !hold;
	assign room     = (count_q < CNT_W'(MAX_LEN));

	// store the byte while there is room
	assign bwr.we   = take && room;
	assign bwr.addr = count_q[BYTE_AW-1:0];
	assign bwr.data = symbol;

	// close the string on the flagged byte
	assign push    = take && last_symbol;
	assign job.n   = room ? count_q + CNT_W'(1) : count_q;
	assign job.ovf = ovf_q || !room;

	// advance count, track dropped bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (take) begin
			if (last_symbol) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else if (room) begin
				count_q <= count_q + CNT_W'(1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

endmodule

FILE: hw/rtl/lpf_queue.sv
module lpf_queue import lpf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wjob,
	input  logic pop,
	output logic empty,
	output job_t head
);

	job_t       ent_q [2];
	logic       rd_q;
	logic       wr_q;
	logic [1:0] cnt_q;

	assign empty = (cnt_q == 2'd0);
	assign head  = ent_q[rd_q];

	// write entries
	always_ff @(posedge clk) begin
		if (push && cnt_q != 2'd2) begin
			ent_q[wr_q] <= wjob;
		end
	end

	// advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push && cnt_q != 2'd2) begin
				wr_q <= !wr_q;
			end
			if (pop && !empty) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'((push && cnt_q != 2'd2) ? 1 : 0)
			       - 2'((pop && !empty) ? 1 : 0);
		end
	end

endmodule

FILE: hw/rtl/lpf_back.sv
module lpf_back import lpf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  job_t               q_head,
	output logic               pop,
	output logic               busy,
	output logic [BYTE_AW-1:0] raddr_l,
	output logic [BYTE_AW-1:0] raddr_r,
	input  logic [SYM_W-1:0]   rdata_l,
	input  logic [SYM_W-1:0]   rdata_r,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [START_W-1:0] start_index,
	output logic [LEN_W-1:0]   palindrome_length,
	output logic               overflow
);

	srch_state_t state_q, state_d;
	logic [IL_W-1:0]  i_q, a_q, last_q, edge_q, ctr_q, bc_q;
	logic [LEN_W-1:0] bs_q;
	logic             ovf_q;
	logic             ov_q;
	logic [START_W-1:0] st_q;
	logic [LEN_W-1:0]   len_q;
	logic             ovo_q;

	logic [IL_W-1:0]  mirror, reach_gap, m_ext, a_mir, l_pos, r_pos, top;
	logic [LEN_W-1:0] span;
	logic             can_grow, out_free, rad_we;
	logic [LEN_W-1:0] rad_rdata;

	assign out_free = !ov_q || !out_stall;
	assign busy     = (state_q != S_IDLE);
	assign pop      = (state_q == S_IDLE) && !q_empty;

	// mirror lookup and its clamp
	assign mirror    = IL_W'({ctr_q, 1'b0}) - i_q;
	assign reach_gap = edge_q - i_q;
	assign m_ext     = IL_W'(rad_rdata);
	assign a_mir     = (m_ext < reach_gap) ? ((m_ext == '0) ? IL_W'(1) : m_ext)
	                                       : ((reach_gap == '0) ? IL_W'(1) : reach_gap);

	// compare positions and byte addresses
	assign l_pos    = i_q - a_q;
	assign r_pos    = i_q + a_q;
	assign can_grow = (a_q < i_q) && (r_pos < last_q);
	assign raddr_l  = BYTE_AW'((l_pos - IL_W'(1)) >> 1);
	assign raddr_r  = BYTE_AW'((r_pos - IL_W'(1)) >> 1);

	// bytes covered by the current palindrome
	assign top  = r_pos - IL_W'(1);
	assign span = top[0] ? LEN_W'(a_q) : LEN_W'(a_q - IL_W'(1));

	assign rad_we = (state_q == S_UPD);

	lpf_ram #(.WIDTH(LEN_W), .DEPTH(IL_DEPTH)) u_radius (
		.clk   (clk),
		.we    (rad_we),
		.waddr (i_q),
		.wdata (LEN_W'(a_q)),
		.raddr (mirror),
		.rdata (rad_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (!q_empty) state_d = S_POS;
			S_POS: begin
				if (i_q >= last_q) state_d = S_FIN;
				else if (i_q < edge_q) state_d = S_MIR;
				else state_d = S_CHK;
			end
			S_MIR: state_d = S_CHK;
			S_CHK: begin
				if (!can_grow) state_d = S_UPD;
				else if (l_pos[0]) state_d = S_CMP;
			end
			S_CMP: state_d = (rdata_l == rdata_r) ? S_CHK : S_UPD;
			S_UPD: state_d = S_POS;
			S_FIN: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// search registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q    <= '0;
			a_q    <= '0;
			last_q <= '0;
			edge_q <= '0;
			ctr_q  <= '0;
			bc_q   <= '0;
			bs_q   <= '0;
			ovf_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (!q_empty) begin
					i_q    <= IL_W'(1);
					last_q <= IL_W'({q_head.n, 1'b0});
					edge_q <= '0;
					ctr_q  <= '0;
					bc_q   <= IL_W'(1);
					bs_q   <= '0;
					ovf_q  <= q_head.ovf;
				end
				S_POS: a_q <= IL_W'(1);
				S_MIR: a_q <= a_mir;
				S_CHK: if (can_grow && !l_pos[0]) a_q <= a_q + IL_W'(1);
				S_CMP: if (rdata_l == rdata_r) a_q <= a_q + IL_W'(1);
				S_UPD: begin
					if (edge_q < r_pos) begin
						ctr_q  <= i_q;
						edge_q <= r_pos;
					end
					if (span > bs_q) begin
						bs_q <= span;
						bc_q <= i_q;
					end
					i_q <= i_q + IL_W'(1);
				end
				default: ;
			endcase
		end
	end

	// hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (state_q == S_FIN && out_free) begin
			ov_q <= 1'b1;
		end else if (!out_stall) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && out_free) begin
			st_q  <= START_W'((bc_q - IL_W'(bs_q)) >> 1);
			len_q <= bs_q;
			ovo_q <= ovf_q;
		end
	end

	assign out_valid         = ov_q;
	assign start_index       = st_q;
	assign palindrome_length = len_q;
	assign overflow          = ovo_q;

endmodule

FILE: hw/rtl/longest_palindrome_finder.sv
// Search: after the flagged byte, each of the 2n-1 search positions steps through S_POS,
// S_MIR when a mirror lookup applies, S_CHK, one S_CMP per byte compare (separator steps
// stay in S_CHK), and S_UPD; S_FIN then registers the result and raises out_valid.
// Throughput: one byte per cycle while loading; the next string loads once the
// search of the previous one has finished; search time is set by the byte store ports.
// Reset clears all control state; byte and radius stores are undefined until written.
module longest_palindrome_finder import lpf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [SYM_W-1:0]   symbol,
	input  logic               last_symbol,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [START_W-1:0] start_index,
	output logic [LEN_W-1:0]   palindrome_length,
	output logic               overflow
);

	bwr_t               bwr;
	job_t               job, head;
	logic               push, pop, q_empty, busy;
	logic [BYTE_AW-1:0] raddr_l, raddr_r;
	logic [SYM_W-1:0]   rdata_l, rdata_r;

	lpf_front u_front (
		.clk (clk), .arst_n (arst_n), .in_valid (in_valid), .in_stall (in_stall),
		.symbol (symbol), .last_symbol (last_symbol), .hold (busy || !q_empty),
		.bwr (bwr), .push (push), .job (job)
	);

	// two copies of the byte store, one per compare side
	lpf_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_bytes_l (
		.clk (clk), .we (bwr.we), .waddr (bwr.addr), .wdata (bwr.data),
		.raddr (raddr_l), .rdata (rdata_l)
	);

	lpf_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_bytes_r (
		.clk (clk), .we (bwr.we), .waddr (bwr.addr), .wdata (bwr.data),
		.raddr (raddr_r), .rdata (rdata_r)
	);

	lpf_queue u_queue (
		.clk (clk), .arst_n (arst_n), .push (push), .wjob (job),
		.pop (pop), .empty (q_empty), .head (head)
	);

	lpf_back u_back (
		.clk (clk), .arst_n (arst_n), .q_empty (q_empty), .q_head (head),
		.pop (pop), .busy (busy), .raddr_l (raddr_l), .raddr_r (raddr_r),
		.rdata_l (rdata_l), .rdata_r (rdata_r), .out_valid (out_valid),
		.out_stall (out_stall), .start_index (start_index),
		.palindrome_length (palindrome_length), .overflow (overflow)
	);

endmodule

FILE: hw/rtl/lpf_checker.sv
module lpf_checker import lpf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               last_symbol,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [START_W-1:0] start_index,
	input  logic [LEN_W-1:0]   palindrome_length
);

	// hold a stalled result transaction
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(start_index)
		&& $stable(palindrome_length))
		else $error("stalled result changed");

	// never report an empty palindrome
	a_len_nz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> palindrome_length != '0)
		else $error("zero length result");

	// keep the palindrome inside the store
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (LEN_W + 1)'(start_index) + (LEN_W + 1)'(palindrome_length)
		<= (LEN_W + 1)'(MAX_LEN))
		else $error("result outside string");

	// stall input after a string closes
	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_symbol |=> in_stall)
		else $error("input taken during search");

endmodule

bind longest_palindrome_finder lpf_checker u_lpf_checker (
	.clk (clk), .arst_n (arst_n), .in_valid (in_valid), .in_stall (in_stall),
	.last_symbol (last_symbol), .out_valid (out_valid), .out_stall (out_stall),
	.start_index (start_index), .palindrome_length (palindrome_length)
);

FILE: tb/longest_palindrome_finder_tb.sv
`timescale 1ns / 1ps

module longest_palindrome_finder_tb;
	import lpf_pkg::*;

	typedef struct {
		logic [SYM_W-1:0] sym;
		logic             last;
	} byte_item_t;

	typedef struct {
		logic [START_W-1:0] start;
		logic [LEN_W-1:0]   len;
		logic               ovf;
	} pal_result_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [SYM_W-1:0]   symbol;
	logic               last_symbol;
	logic               out_valid;
	logic               out_stall;
	logic [START_W-1:0] start_index;
	logic [LEN_W-1:0]   palindrome_length;
	logic               overflow;

	byte_item_t  pending_bytes[$];
	pal_result_t expected_results[$];
	logic [SYM_W-1:0] string_buf[$];
	int  send_idle_pct;
	int  recv_stall_pct;
	bit  recv_hold;
	bit  send_hold;
	bit  ovf_flag;
	int  fail_count;

	longest_palindrome_finder u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.symbol(symbol), .last_symbol(last_symbol),
		.out_valid(out_valid), .out_stall(out_stall),
		.start_index(start_index), .palindrome_length(palindrome_length),
		.overflow(overflow)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// compute the longest palindrome of the string stored so far (Manacher, interleaved)
	function automatic pal_result_t longest_palindrome(input logic [SYM_W-1:0] s[$],
			input bit ovf);
		int n;
		int last_pos;
		int edge_r;
		int ctr;
		int best_c;
		int best_s;
		int rad[];
		int a;
		int m;
		int span;
		pal_result_t r;
		n = s.size();
		last_pos = 2 * n;
		rad = new[last_pos + 1];
		edge_r = 0;
		ctr = 0;
		best_c = 1;
		best_s = 0;
		for (int i = 1; i < last_pos; i++) begin
			a = 1;
			if (i < edge_r) begin
				m = rad[2 * ctr - i];
				a = edge_r - i;
				if (m < a)
					a = m;
				if (a == 0)
					a = 1;
			end
			while (a < i && i + a < last_pos &&
					(((i - a) % 2 == 0) || s[(i - a - 1) / 2] == s[(i + a - 1) / 2]))
				a++;
			rad[i] = a;
			if (edge_r < i + a) begin
				ctr = i;
				edge_r = i + a;
			end
			span = ((i + a - 1) % 2 != 0) ? a : a - 1;
			if (span > best_s) begin
				best_s = span;
				best_c = i;
			end
		end
		r.start = START_W'((best_c - best_s) / 2);
		r.len   = LEN_W'(best_s);
		r.ovf   = ovf;
		return r;
	endfunction

	// queue one string; alphabet size controls how often palindromes appear
	task automatic queue_string(input int len, input int alpha);
		byte_item_t it;
		for (int k = 0; k < len; k++) begin
			it.sym  = (alpha >= 256) ? SYM_W'($urandom) : SYM_W'($urandom_range(alpha - 1, 0));
			if (alpha < 256 && $urandom_range(1, 0))
				it.sym = it.sym + 8'd60;
			it.last = (k == len - 1);
			pending_bytes.insert(pending_bytes.size(), it);
		end
	endtask

	task automatic queue_palindrome(input int half, input bit odd);
		byte_item_t it;
		logic [SYM_W-1:0] h[$];
		for (int k = 0; k < half; k++)
			h.insert(h.size(), SYM_W'($urandom_range(3, 0)));
		if (odd)
			h.insert(h.size(), SYM_W'($urandom));
		for (int k = half - 1; k >= 0; k--)
			h.insert(h.size(), h[k]);
		foreach (h[k]) begin
			it.sym  = h[k];
			it.last = (k == h.size() - 1);
			pending_bytes.insert(pending_bytes.size(), it);
		end
	endtask

	task automatic queue_fixed(input logic [SYM_W-1:0] v[$]);
		byte_item_t it;
		foreach (v[k]) begin
			it.sym  = v[k];
			it.last = (k == v.size() - 1);
			pending_bytes.insert(pending_bytes.size(), it);
		end
	endtask

	task automatic wait_drained();
		while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	// driver: present pending bytes, hold payload while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid    <= 1'b0;
			symbol      <= '0;
			last_symbol <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (pending_bytes.size() != 0 && !send_hold &&
					$urandom_range(99, 0) >= send_idle_pct) begin
				byte_item_t it;
				it = pending_bytes.pop_front();
				in_valid    <= 1'b1;
				symbol      <= it.sym;
				last_symbol <= it.last;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// predictor: collect accepted bytes, mark dropped ones, compute result on the flagged one
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			if (string_buf.size() < MAX_LEN)
				string_buf.insert(string_buf.size(), symbol);
			else
				ovf_flag = 1'b1;
			if (last_symbol) begin
				expected_results.insert(expected_results.size(),
					longest_palindrome(string_buf, ovf_flag));
				string_buf.delete();
				ovf_flag = 1'b0;
			end
		end
	end

	// receiver stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= recv_hold || ($urandom_range(99, 0) < recv_stall_pct);
	end

	// monitor: compare each result transaction against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result: start %0d length %0d overflow %0d",
					start_index, palindrome_length, overflow);
				fail_count++;
			end else begin
				pal_result_t e;
				e = expected_results.pop_front();
				if (start_index !== e.start) begin
					$error("start_index: expected %0d actual %0d", e.start, start_index);
					fail_count++;
				end
				if (palindrome_length !== e.len) begin
					$error("palindrome_length: expected %0d actual %0d", e.len,
						palindrome_length);
					fail_count++;
				end
				if (overflow !== e.ovf) begin
					$error("overflow: expected %0d actual %0d", e.ovf, overflow);
					fail_count++;
				end
			end
		end
	end

	initial begin
		#100ms;
		$display("tb: failure");
		$finish;
	end

	initial begin
		logic [SYM_W-1:0] v[$];
		int sent;
		fail_count     = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		recv_hold      = 0;
		send_hold      = 0;
		ovf_flag       = 0;
		arst_n         = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: single bytes at the extremes, ties, byte values once used as markers
		v = '{8'h00};                         queue_fixed(v);
		v = '{8'hFF};                         queue_fixed(v);
		v = '{8'h41, 8'h42};                  queue_fixed(v);
		v = '{8'h40, 8'h24, 8'h23, 8'h24, 8'h40}; queue_fixed(v);
		v = '{8'h23, 8'h23, 8'h61, 8'h23};    queue_fixed(v);
		v = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'h55}; queue_fixed(v);
		v = '{8'hAA, 8'h55, 8'hAA, 8'h55};    queue_fixed(v);
		wait_drained();

		// overflow: one string beyond capacity
		queue_string(MAX_LEN + 3, 2);
		wait_drained();

		// random phases with different idling
		sent = 0;
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = (ph == 1 || ph == 3) ? 73 : 0;
			recv_stall_pct = (ph == 2 || ph == 3) ? 73 : 0;
			if (ph == 3) begin
				send_idle_pct  = 6;
				recv_stall_pct = 6;
			end
			for (int s = 0; s < 6; s++) begin
				case ($urandom_range(3, 0))
					0: queue_string($urandom_range(12, 1), 256);
					1: queue_palindrome($urandom_range(5, 0), $urandom_range(1, 0));
					default: queue_string($urandom_range(12, 1), $urandom_range(3, 2));
				endcase
			end
			if (ph == 0) begin
				// long receiver hold while the sender keeps offering
				recv_hold = 1;
				repeat (300) @(posedge clk);
				recv_hold = 0;
			end
			wait_drained();
			// sender pause after every result has come
			send_hold = 1;
			repeat (20) @(posedge clk);
			send_hold = 0;
		end
		repeat (200) @(posedge clk);
		if (fail_count == 0 && expected_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
